### hw/rtl/hrsp_pkg.sv
// package for the http request stream parser: byte roles, phases, status and method codes
// no dependencies
`timescale 1ns / 1ps
package hrsp_pkg;

    typedef enum logic [3:0] {
        ROLE_METHOD  = 4'd0,
        ROLE_PATH    = 4'd1,
        ROLE_QUERY   = 4'd2,
        ROLE_VERSION = 4'd3,
        ROLE_KEY     = 4'd4,
        ROLE_VALUE   = 4'd5,
        ROLE_BODY    = 4'd6,
        ROLE_DELIM   = 4'd7,
        ROLE_IGNORE  = 4'd8
    } role_t;

    typedef enum logic [7:0] {
        PH_METHOD  = 8'b0000_0001,
        PH_PATH    = 8'b0000_0010,
        PH_QUERY   = 8'b0000_0100,
        PH_VERSION = 8'b0000_1000,
        PH_KEY     = 8'b0001_0000,
        PH_LEAD    = 8'b0010_0000,
        PH_VALUE   = 8'b0100_0000,
        PH_BODY    = 8'b1000_0000
    } phase_t;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_INC_HEADER = 3'd1;
    localparam logic [2:0] ST_BAD_LINE   = 3'd2;
    localparam logic [2:0] ST_BAD_URI    = 3'd3;
    localparam logic [2:0] ST_INC_BODY   = 3'd4;

    localparam logic [2:0] METH_UNKNOWN = 3'd7;

    localparam logic [1:0] LK_OTHER  = 2'd0;
    localparam logic [1:0] LK_LENGTH = 2'd1;
    localparam logic [1:0] LK_CONN   = 2'd2;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } req_word_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [3:0]  byte_role;
        logic [7:0]  header_number;
        logic        line_was_header;
        logic        request_done;
        logic [2:0]  parse_status;
        logic [2:0]  method_code;
        logic        keep_conn;
        logic [31:0] content_length;
    } res_word_t;

    // method text, byte at position in 0..7, zero past the end
    function automatic logic [7:0] verb_char(input logic [2:0] v, input logic [3:0] p);
        logic [63:0] s;
        begin
            case (v)
                3'd0:    s = {"GET", 40'h0};
                3'd1:    s = {"POST", 32'h0};
                3'd2:    s = {"PUT", 40'h0};
                3'd3:    s = {"DELETE", 16'h0};
                3'd4:    s = {"PATCH", 24'h0};
                3'd5:    s = {"HEAD", 32'h0};
                3'd6:    s = {"OPTIONS", 8'h0};
                default: s = 64'h0;
            endcase
            verb_char = (p > 4'd7) ? 8'h0 : s[63 - 8 * p[2:0] -: 8];
        end
    endfunction

    function automatic logic [3:0] verb_len(input logic [2:0] v);
        begin
            case (v)
                3'd0:    verb_len = 4'd3;
                3'd1:    verb_len = 4'd4;
                3'd2:    verb_len = 4'd3;
                3'd3:    verb_len = 4'd6;
                3'd4:    verb_len = 4'd5;
                3'd5:    verb_len = 4'd4;
                3'd6:    verb_len = 4'd7;
                default: verb_len = 4'd0;
            endcase
        end
    endfunction

    function automatic logic [7:0] len_key_char(input logic [3:0] p);
        logic [111:0] s;
        begin
            s = "content-length";
            len_key_char = (p > 4'd13) ? 8'h0 : s[111 - 8 * p -: 8];
        end
    endfunction

    function automatic logic [7:0] conn_key_char(input logic [3:0] p);
        logic [79:0] s;
        begin
            s = "connection";
            conn_key_char = (p > 4'd9) ? 8'h0 : s[79 - 8 * p -: 8];
        end
    endfunction

    function automatic logic [7:0] close_char(input logic [2:0] p);
        logic [39:0] s;
        begin
            s = "close";
            close_char = (p > 3'd4) ? 8'h0 : s[39 - 8 * p -: 8];
        end
    endfunction

endpackage

### hw/rtl/hrsp_stream_if.sv
// valid/ready stream interface carrying one word of a given type
// depends on nothing; payload type set per instance
`timescale 1ns / 1ps
interface hrsp_stream_if #(parameter type word_t = logic [7:0]);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/http_request_stream_parser_unit.sv
// http request stream parser top level: per-byte role tagging and final verdict
// depends on hrsp_pkg and hrsp_stream_if
`timescale 1ns / 1ps
// One request byte enters per cycle and yields exactly one result word, in
// order. All parsing state updates in a single pass between the accepted
// byte and the output register; a skid register holds one more result when
// the sink stalls, so input ready only drops once both are full. Sustained
// rate is one byte per clock while the sink is ready. The word marked
// end_of_buffer carries the verdict (status, method, keep-alive, content
// length) and the parser returns to its reset state for the next buffer.
module http_request_stream_parser_unit #(
    parameter int LENGTH_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    hrsp_stream_if.sink   req,
    hrsp_stream_if.source res
);
    import hrsp_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
    localparam int WB = LENGTH_BITS + 4;

    // parse state
    phase_t                 phase_reg, phase_next;
    logic [6:0]             mcand_reg, mcand_next;
    logic [3:0]             tpos_reg, tpos_next;
    logic [1:0]             term_reg, term_next;
    logic [1:0]             kcand_reg, kcand_next;
    logic [1:0]             lkind_reg, lkind_next;
    logic                   lseen_reg, lseen_next;
    logic                   cseen_reg, cseen_next;
    logic [LENGTH_BITS-1:0] acc_reg, acc_next;
    logic                   cmatch_reg, cmatch_next;
    logic [2:0]             vlen_reg, vlen_next;
    logic                   ka_reg, ka_next;
    logic [LENGTH_BITS-1:0] brem_reg, brem_next;
    logic [7:0]             hcnt_reg, hcnt_next;
    logic [2:0]             lerr_reg, lerr_next;
    logic [2:0]             meth_reg, meth_next;

    // output and skid registers
    logic      out_valid_reg, skid_valid_reg;
    res_word_t out_reg, skid_reg, result;

    logic      accept;
    assign req.ready = !skid_valid_reg;
    assign accept    = req.valid && req.ready;
    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;

    logic [7:0] b, ob;
    logic       last, crlf, digit;
    logic [3:0] role;
    logic       lwh;
    logic [3:0] dval;
    logic [WB-1:0] acc_x10;
    logic [2:0] st;

    assign b    = req.data.data_byte;
    assign last = req.data.end_of_buffer;

    always_comb
    begin
        phase_next  = phase_reg;
        mcand_next  = mcand_reg;
        tpos_next   = tpos_reg;
        kcand_next  = kcand_reg;
        lkind_next  = lkind_reg;
        lseen_next  = lseen_reg;
        cseen_next  = cseen_reg;
        acc_next    = acc_reg;
        cmatch_next = cmatch_reg;
        vlen_next   = vlen_reg;
        ka_next     = ka_reg;
        brem_next   = brem_reg;
        hcnt_next   = hcnt_reg;
        lerr_next   = lerr_reg;
        meth_next   = meth_reg;
        ob          = b;
        role        = ROLE_IGNORE;
        lwh         = 1'b0;
        digit       = (b >= "0") && (b <= "9");
        dval        = b[3:0] - 4'd0;
        acc_x10     = {4'd0, acc_reg} * WB'(10) + WB'(dval);

        // terminator tracking
        crlf = (phase_reg != PH_BODY) && (b == CH_LF) && (term_reg == 2'd1 || term_reg == 2'd3);
        if (b == CH_CR)
            term_next = (term_reg == 2'd2) ? 2'd3 : 2'd1;
        else if (b == CH_LF)
            term_next = (term_reg == 2'd1) ? 2'd2 : 2'd0;
        else
            term_next = 2'd0;

        if (crlf && (phase_reg == PH_METHOD || phase_reg == PH_PATH
                     || phase_reg == PH_QUERY || phase_reg == PH_VERSION))
        begin
            // end of request line
            if (phase_reg == PH_METHOD)
                lerr_next = ST_BAD_LINE;
            else if (phase_reg != PH_VERSION)
                lerr_next = ST_BAD_URI;
            role        = ROLE_DELIM;
            tpos_next   = 4'd0;
            kcand_next  = 2'b11;
            lkind_next  = LK_OTHER;
            cmatch_next = 1'b1;
            vlen_next   = 3'd0;
            phase_next  = PH_KEY;
        end
        else if (crlf)
        begin
            role = ROLE_DELIM;
            if (term_reg == 2'd3)
            begin
                phase_next = PH_BODY;
                brem_next  = lseen_reg ? acc_reg : '0;
            end
            else
            begin
                lwh = (phase_reg != PH_KEY);
                if (lkind_reg == LK_CONN)
                    ka_next = !(cmatch_reg && vlen_reg == 3'd6);
                if (hcnt_reg != 8'hFF)
                    hcnt_next = hcnt_reg + 8'd1;
                tpos_next   = 4'd0;
                kcand_next  = 2'b11;
                lkind_next  = LK_OTHER;
                cmatch_next = 1'b1;
                vlen_next   = 3'd0;
                phase_next  = PH_KEY;
            end
        end
        else
        begin
            case (phase_reg)
                PH_METHOD:
                begin
                    if (b == CH_SPACE)
                    begin
                        meth_next = METH_UNKNOWN;
                        for (int i = 0; i < 7; i++)
                            if (mcand_reg[i] && verb_len(3'(i)) == tpos_reg)
                                meth_next = 3'(i);
                        role       = ROLE_DELIM;
                        phase_next = PH_PATH;
                    end
                    else
                    begin
                        for (int i = 0; i < 7; i++)
                            if (tpos_reg >= verb_len(3'(i)) || verb_char(3'(i), tpos_reg) != b)
                                mcand_next[i] = 1'b0;
                        if (tpos_reg != 4'd15)
                            tpos_next = tpos_reg + 4'd1;
                        role = ROLE_METHOD;
                    end
                end
                PH_PATH, PH_QUERY:
                begin
                    if (b == CH_SPACE)
                    begin
                        role       = ROLE_DELIM;
                        phase_next = PH_VERSION;
                    end
                    else if (b == CH_QMARK && phase_reg == PH_PATH)
                    begin
                        role       = ROLE_DELIM;
                        phase_next = PH_QUERY;
                    end
                    else
                        role = (phase_reg == PH_PATH) ? ROLE_PATH : ROLE_QUERY;
                end
                PH_VERSION: role = ROLE_VERSION;
                PH_KEY:
                begin
                    if (b == CH_COLON)
                    begin
                        if (kcand_reg[0] && tpos_reg == 4'd14 && !lseen_reg)
                        begin
                            lkind_next = LK_LENGTH;
                            lseen_next = 1'b1;
                        end
                        else if (kcand_reg[1] && tpos_reg == 4'd10 && !cseen_reg)
                        begin
                            lkind_next = LK_CONN;
                            cseen_next = 1'b1;
                        end
                        role       = ROLE_DELIM;
                        phase_next = PH_LEAD;
                    end
                    else
                    begin
                        if (b >= "A" && b <= "Z")
                            ob = b + 8'h20;
                        if (tpos_reg >= 4'd14 || len_key_char(tpos_reg) != ob)
                            kcand_next[0] = 1'b0;
                        if (tpos_reg >= 4'd10 || conn_key_char(tpos_reg) != ob)
                            kcand_next[1] = 1'b0;
                        if (tpos_reg != 4'd15)
                            tpos_next = tpos_reg + 4'd1;
                        role = ROLE_KEY;
                    end
                end
                PH_LEAD, PH_VALUE:
                begin
                    if (phase_reg == PH_LEAD && b == CH_SPACE)
                        role = ROLE_IGNORE;
                    else
                    begin
                        phase_next = PH_VALUE;
                        role       = ROLE_VALUE;
                        if (lkind_reg == LK_LENGTH && digit)
                        begin
                            if (acc_x10[WB-1:LENGTH_BITS] != '0)
                                acc_next = LEN_MAX;
                            else
                                acc_next = acc_x10[LENGTH_BITS-1:0];
                        end
                        else if (lkind_reg == LK_CONN)
                        begin
                            if (vlen_reg < 3'd5 && (b | 8'h20) != close_char(vlen_reg))
                                cmatch_next = 1'b0;
                            if (vlen_reg != 3'd7)
                                vlen_next = vlen_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    if (brem_reg != '0)
                    begin
                        role      = ROLE_BODY;
                        brem_next = brem_reg - 1'b1;
                    end
                end
            endcase
        end

        // verdict from the updated state
        if (phase_next != PH_BODY)
            st = ST_INC_HEADER;
        else if (lerr_next != ST_OK)
            st = lerr_next;
        else if (brem_next != '0)
            st = ST_INC_BODY;
        else
            st = ST_OK;

        result                 = '0;
        result.out_byte        = ob;
        result.byte_role       = role;
        result.header_number   = hcnt_next;
        result.line_was_header = lwh;
        result.request_done    = last;
        if (last)
        begin
            result.parse_status = st;
            if (st == ST_OK || st == ST_INC_BODY)
            begin
                result.method_code = meth_next;
                result.keep_conn   = ka_next;
                if (LENGTH_BITS > 32 && (acc_next >> 32) != '0)
                    result.content_length = 32'hFFFF_FFFF;
                else
                    result.content_length = 32'(acc_next);
            end
            else
            begin
                result.method_code = METH_UNKNOWN;
                result.keep_conn   = 1'b1;
            end
        end
    end

    // parse state registers, cleared again after the final word of a buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_METHOD;
            mcand_reg  <= 7'h7F;
            tpos_reg   <= 4'd0;
            term_reg   <= 2'd0;
            kcand_reg  <= 2'b11;
            lkind_reg  <= LK_OTHER;
            lseen_reg  <= 1'b0;
            cseen_reg  <= 1'b0;
            acc_reg    <= '0;
            cmatch_reg <= 1'b1;
            vlen_reg   <= 3'd0;
            ka_reg     <= 1'b1;
            brem_reg   <= '0;
            hcnt_reg   <= 8'd0;
            lerr_reg   <= ST_OK;
            meth_reg   <= METH_UNKNOWN;
        end
        else if (accept && last)
        begin
            phase_reg  <= PH_METHOD;
            mcand_reg  <= 7'h7F;
            tpos_reg   <= 4'd0;
            term_reg   <= 2'd0;
            kcand_reg  <= 2'b11;
            lkind_reg  <= LK_OTHER;
            lseen_reg  <= 1'b0;
            cseen_reg  <= 1'b0;
            acc_reg    <= '0;
            cmatch_reg <= 1'b1;
            vlen_reg   <= 3'd0;
            ka_reg     <= 1'b1;
            brem_reg   <= '0;
            hcnt_reg   <= 8'd0;
            lerr_reg   <= ST_OK;
            meth_reg   <= METH_UNKNOWN;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            mcand_reg  <= mcand_next;
            tpos_reg   <= tpos_next;
            term_reg   <= term_next;
            kcand_reg  <= kcand_next;
            lkind_reg  <= lkind_next;
            lseen_reg  <= lseen_next;
            cseen_reg  <= cseen_next;
            acc_reg    <= acc_next;
            cmatch_reg <= cmatch_next;
            vlen_reg   <= vlen_next;
            ka_reg     <= ka_next;
            brem_reg   <= brem_next;
            hcnt_reg   <= hcnt_next;
            lerr_reg   <= lerr_next;
            meth_reg   <= meth_next;
        end
    end

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || res.ready)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                    out_valid_reg <= accept;
            end
            else if (accept)
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || res.ready)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= result;
        end
        if (accept && !skid_valid_reg && out_valid_reg && !res.ready)
            skid_reg <= result;
    end

`ifndef SYNTHESIS
    // skid stage only fills behind a full output register
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid valid without output valid");
    // final word returns parser to method phase
    a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> phase_reg == PH_METHOD && hcnt_reg == 8'd0)
        else $error("parser not reset after final word");
    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res.ready |=> out_valid_reg && $stable(out_reg))
        else $error("output changed while stalled");
`endif
endmodule
